>>> design/stat_record_parser_core_assert.svh
// Assertion macros shared by the stat record parser modules.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef STAT_RECORD_PARSER_CORE_ASSERT_SVH
`define STAT_RECORD_PARSER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define SRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define SRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SRP_ASSERT(lbl, prop, msg)
`define SRP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> design/srp_pkg.sv
// Types, constants and tables for the stat record parser.
// Used by srp_parse, srp_outq and stat_record_parser_core.
package srp_pkg;

  localparam int unsigned POS_W  = 17;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned SLOTS  = 3;

  localparam logic [4:0] PH_SIZE = 5'd0;
  localparam logic [4:0] PH_STR0 = 5'd10;
  localparam logic [4:0] PH_DONE = 5'd22;

  localparam logic [POS_W-1:0] FIX_LEN = 17'd49;
  localparam logic [POS_W-1:0] POS_MAX = 17'd131071;

  // configuration register indexes
  localparam logic CFG_STRICT = 1'b0;
  localparam logic CFG_COPY   = 1'b1;

  typedef enum logic [1:0] {
    KIND_FIXED  = 2'd0,
    KIND_SBYTE  = 2'd1,
    KIND_SEND   = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_SIZE_ERR = 2'd2,
    ST_TRAILING = 2'd3
  } status_t;

  // one result word
  typedef struct packed {
    kind_t             kind;
    logic [3:0]        idx;
    logic [VAL_W-1:0]  val;
    status_t           status;
    logic [POS_W-1:0]  consumed;
    logic              last;
  } res_t;

  // results caused by one input byte
  typedef struct packed {
    res_t [SLOTS-1:0] slot;
    logic [1:0]       cnt;
  } bundle_t;

  // byte offset where each fixed field starts
  function automatic logic [5:0] fld_start(input logic [3:0] f);
    logic [5:0] s;
    case (f)
      4'd0:    s = 6'd2;
      4'd1:    s = 6'd4;
      4'd2:    s = 6'd8;
      4'd3:    s = 6'd9;
      4'd4:    s = 6'd13;
      4'd5:    s = 6'd21;
      4'd6:    s = 6'd25;
      4'd7:    s = 6'd29;
      default: s = 6'd33;
    endcase
    return s;
  endfunction

  // byte length of each fixed field
  function automatic logic [3:0] fld_len(input logic [3:0] f);
    logic [3:0] l;
    case (f)
      4'd0:    l = 4'd2;
      4'd2:    l = 4'd1;
      4'd4:    l = 4'd8;
      4'd8:    l = 4'd8;
      default: l = 4'd4;
    endcase
    return l;
  endfunction

endpackage

>>> design/srp_parse.sv
// Parser state and per-byte decode for the stat record parser.
// Depends on srp_pkg; hands a bundle of up to three results to srp_outq.
`include "stat_record_parser_core_assert.svh"

module srp_parse
  import srp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    data_byte,
  input  logic          end_of_buffer,
  input  logic          strict_check,
  input  logic          copy_strings,
  output bundle_t       bundle
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [4:0]       phase_r, phase_nxt;
  logic [15:0]      srem_r, srem_nxt;
  logic [15:0]      dsize_r, dsize_nxt;
  logic             cmp_r, cmp_nxt;
  logic [POS_W-1:0] endp_r, endp_nxt;

  logic [3:0]       f;
  logic [2:0]       sh;
  logic [VAL_W-1:0] acc_or;
  logic [4:0]       rel;
  logic [7:0]       kmul;
  logic [1:0]       k;
  logic [1:0]       sub;
  logic [4:0]       phase_next_str;
  logic [15:0]      srem_hi;
  logic [15:0]      srem_dec;
  logic [3:0]       str_idx;
  logic [POS_W-1:0] size_plus2;
  status_t          st;
  res_t [SLOTS-1:0] cand;
  logic [SLOTS-1:0] cand_v;
  res_t [SLOTS-1:0] slots;
  logic [1:0]       n;

  // field and string bookkeeping
  always_comb begin
    f       = phase_r[3:0] - 4'd1;
    sh      = 3'(pos_r - {11'd0, fld_start(f)});
    acc_or  = acc_r | ({{(VAL_W-8){1'b0}}, data_byte} << {sh, 3'b000});
    rel     = phase_r - PH_STR0;
    // rel / 3 for rel below 12
    kmul    = {3'b000, rel} * 8'd11;
    k       = kmul[6:5];
    sub     = 2'(rel - {2'b00, k, 1'b0} - {3'b000, k});
    phase_next_str = phase_r + 5'd3 - {3'b000, sub};
    srem_hi  = srem_r | {data_byte, 8'h00};
    srem_dec = srem_r - 16'd1;
    str_idx  = 4'd9 + {2'b00, k};
  end

  // next state and candidate results
  always_comb begin
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    phase_nxt = phase_r;
    srem_nxt  = srem_r;
    dsize_nxt = dsize_r;
    cmp_nxt   = cmp_r;
    endp_nxt  = endp_r;
    cand      = '0;
    cand_v    = '0;
    st        = ST_OK;

    if (phase_r == PH_SIZE) begin
      if (pos_r == '0) begin
        dsize_nxt = {8'h00, data_byte};
      end else begin
        dsize_nxt = dsize_r | {data_byte, 8'h00};
        phase_nxt = 5'd1;
        acc_nxt   = '0;
      end
    end else if (phase_r <= 5'd9) begin
      acc_nxt = acc_or;
      if ({1'b0, sh} + 4'd1 >= fld_len(f)) begin
        cand_v[0]   = 1'b1;
        cand[0].kind = KIND_FIXED;
        cand[0].idx  = f;
        cand[0].val  = acc_or;
        acc_nxt     = '0;
        phase_nxt   = phase_r + 5'd1;
      end
    end else if (phase_r < PH_DONE) begin
      case (sub)
        2'd0: begin
          srem_nxt  = {8'h00, data_byte};
          phase_nxt = phase_r + 5'd1;
        end
        2'd1: begin
          srem_nxt = srem_hi;
          if (srem_hi == '0) begin
            cand_v[1]    = copy_strings;
            phase_nxt    = phase_next_str;
            cmp_nxt      = (phase_next_str == PH_DONE);
          end else begin
            phase_nxt = phase_r + 5'd1;
          end
        end
        default: begin
          cand_v[0]    = copy_strings;
          cand[0].kind = KIND_SBYTE;
          cand[0].idx  = str_idx;
          cand[0].val  = {{(VAL_W-8){1'b0}}, data_byte};
          srem_nxt     = srem_dec;
          if (srem_dec == '0) begin
            cand_v[1] = copy_strings;
            phase_nxt = phase_next_str;
            cmp_nxt   = (phase_next_str == PH_DONE);
          end
        end
      endcase
      cand[1].kind = KIND_SEND;
      cand[1].idx  = str_idx;
    end else begin
      phase_nxt = PH_DONE;
    end

    pos_nxt = (pos_r < POS_MAX) ? pos_r + 17'd1 : POS_MAX;
    if (cmp_nxt && !cmp_r) begin
      endp_nxt = pos_nxt;
    end

    // record status on the last buffer byte
    size_plus2 = {1'b0, dsize_nxt} + 17'd2;
    if (strict_check) begin
      if (pos_nxt < FIX_LEN)          st = ST_TRUNC;
      else if (pos_nxt != size_plus2) st = ST_SIZE_ERR;
      else if (!cmp_nxt)              st = ST_TRUNC;
      else if (endp_nxt != pos_nxt)   st = ST_TRAILING;
      else                            st = ST_OK;
    end else begin
      st = cmp_nxt ? ST_OK : ST_TRUNC;
    end
    cand_v[2]        = end_of_buffer;
    cand[2].kind     = KIND_STATUS;
    cand[2].status   = st;
    cand[2].consumed = (st == ST_OK) ? endp_nxt : '0;

    // back to reset state after the status
    if (end_of_buffer) begin
      pos_nxt   = '0;
      acc_nxt   = '0;
      phase_nxt = PH_SIZE;
      srem_nxt  = '0;
      dsize_nxt = '0;
      cmp_nxt   = 1'b0;
      endp_nxt  = '0;
    end
  end

  // pack valid candidates in order, flag the final one
  always_comb begin
    slots = '0;
    n     = 2'd0;
    for (int i = 0; i < SLOTS; i++) begin
      if (cand_v[i]) begin
        slots[n] = cand[i];
        n        = n + 2'd1;
      end
    end
    if (n != 2'd0) begin
      slots[n - 2'd1].last = 1'b1;
    end
    bundle.slot = slots;
    bundle.cnt  = n;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      acc_r   <= '0;
      phase_r <= PH_SIZE;
      srem_r  <= '0;
      dsize_r <= '0;
      cmp_r   <= 1'b0;
      endp_r  <= '0;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      phase_r <= phase_nxt;
      srem_r  <= srem_nxt;
      dsize_r <= dsize_nxt;
      cmp_r   <= cmp_nxt;
      endp_r  <= endp_nxt;
    end
  end

  `SRP_ASSERT(a_phase_range, phase_r <= PH_DONE, "parse phase out of range")
  `SRP_ASSERT(a_complete_done, cmp_r |-> phase_r == PH_DONE, "complete outside done phase")
  `SRP_ASSERT(a_start_in_size, pos_r == '0 |-> phase_r == PH_SIZE, "record start not in size phase")

endmodule

>>> design/srp_outq.sv
// Result register bank for the stat record parser: holds one byte's results
// and hands them out one word per cycle while res_ready is high. Depends on srp_pkg.
`include "stat_record_parser_core_assert.svh"

module srp_outq
  import srp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  bundle_t bundle,
  output logic    load_ready,
  output logic    res_valid,
  input  logic    res_ready,
  output res_t    res
);

  res_t [SLOTS-1:0] slot_r;
  logic [1:0]       cnt_r;
  logic             take;

  assign take       = res_valid && res_ready;
  // accept a new byte once the bank drains this cycle
  assign load_ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && res_ready);
  assign res_valid  = (cnt_r != 2'd0);
  assign res        = slot_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (fire) begin
      cnt_r <= bundle.cnt;
    end else if (take) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // payload shifts toward slot 0
  always_ff @(posedge clk) begin
    if (fire) begin
      slot_r <= bundle.slot;
    end else if (take) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  `SRP_ASSERT(a_more_follow, res_valid && !res.last |-> cnt_r >= 2'd2, "missing follow-up word")
  `SRP_ASSERT(a_load_shows, fire && bundle.cnt != 2'd0 |=> res_valid, "loaded results not shown")
  `SRP_ASSERT(a_status_last, res_valid && res.kind == KIND_STATUS |-> res.last, "status not last")
  `SRP_ASSERT_ALWAYS(a_load_ok, fire |-> load_ready, "load into busy bank")

endmodule

>>> design/stat_record_parser_core.sv
// Stat record parser top level: stream ports, configuration registers.
// Throughput: one byte per cycle while out_tready is high and each byte gives at most
// one result; a byte with more results holds in_tready low until only its last word is left.
// The first result word is on out_* in the cycle after the byte is taken.
// Reset (rst_n low, synchronous) returns the parser to the record start,
// empties the result bank and sets strict_check 0, copy_strings 1.
module stat_record_parser_core
  import srp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_buffer
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [3:0] field_index, [67:4] field_value,
                                  // [69:68] status_code, [86:70] consumed_length
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  output logic        out_tlast,  // last_of_item
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);

  logic    strict_r;
  logic    copy_r;
  logic    fire;
  bundle_t bundle;
  res_t    res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b0;
      copy_r   <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_STRICT) strict_r <= cfg_wdata;
      if (cfg_index == CFG_COPY)   copy_r   <= cfg_wdata;
    end
  end

  assign fire = in_tvalid && in_tready;

  srp_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .data_byte     (in_tdata),
    .end_of_buffer (in_tlast),
    .strict_check  (strict_r),
    .copy_strings  (copy_r),
    .bundle        (bundle)
  );

  srp_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .bundle     (bundle),
    .load_ready (in_tready),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  // result word packing
  assign out_tdata = {1'b0, res.consumed, res.status, res.val, res.idx};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

>>> test/stat_record_checker.sv
// Scoreboard for stat_record_parser_core: watches the byte, result and config ports,
// predicts every result word from the accepted bytes and compares in order.
// Depends on srp_pkg for the result word layout, kinds, status codes and phase values.
module stat_record_checker
  import srp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_buffer
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,  // [3:0] field_index, [67:4] field_value,
                                  // [69:68] status_code, [86:70] consumed_length
  input  logic [1:0]  out_tuser,  // [1:0] result_kind
  input  logic        out_tlast,  // last_of_item
  output int          fail_count,
  output int          pending_words
);

  localparam int STRING_COUNT     = 4;
  localparam int FIRST_STRING_IDX = 9;
  // byte widths of the nine fixed fields, field 0 in the low nibble
  localparam logic [35:0] FIELD_BYTES =
    {4'd8, 4'd4, 4'd4, 4'd4, 4'd8, 4'd4, 4'd1, 4'd4, 4'd2};

  // mode bits as last written
  logic strict_mode;
  logic copy_mode;

  // parser state
  logic [POS_W-1:0] byte_pos;
  logic [POS_W-1:0] end_pos;
  logic [VAL_W-1:0] field_acc;
  logic [3:0]       field_byte;
  logic [4:0]       phase;
  logic [15:0]      str_left;
  logic [15:0]      declared_size;
  logic             rec_done;

  res_t expected_words[$];

  initial begin
    fail_count    = 0;
    pending_words = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic res_t make_word(input kind_t k, input logic [3:0] idx,
                                     input logic [VAL_W-1:0] v, input status_t st,
                                     input logic [POS_W-1:0] consumed);
    res_t w;
    w.kind     = k;
    w.idx      = idx;
    w.val      = v;
    w.status   = st;
    w.consumed = consumed;
    w.last     = 1'b0;
    return w;
  endfunction

  function automatic void clear_parse();
    byte_pos      = '0;
    end_pos       = '0;
    field_acc     = '0;
    field_byte    = '0;
    phase         = PH_SIZE;
    str_left      = '0;
    declared_size = '0;
    rec_done      = 1'b0;
  endfunction

  // move on to the next length prefix, or mark the record complete
  function automatic void advance_string(input int k);
    if (k + 1 < STRING_COUNT) begin
      phase = 5'(int'(PH_STR0) + 3 * (k + 1));
    end else begin
      phase    = PH_DONE;
      rec_done = 1'b1;
    end
  endfunction

  // one accepted byte: update state, queue the words it causes
  function automatic void parse_stat_byte(input logic [7:0] b, input logic eob);
    res_t             step_words[$];
    logic [POS_W-1:0] pos;
    logic             was_done;
    int               f;
    int               rel;
    int               k;
    status_t          st;
    pos      = byte_pos;
    was_done = rec_done;

    if (phase == PH_SIZE) begin
      // size word, kept but never emitted
      if (pos == 0) begin
        declared_size = {8'h00, b};
      end else begin
        declared_size[15:8] = b;
        phase      = PH_SIZE + 5'd1;
        field_acc  = '0;
        field_byte = '0;
      end
    end else if (phase < PH_STR0) begin
      // little-endian fixed field
      f = int'(phase) - 1;
      field_acc[8*field_byte +: 8] = b;
      if (field_byte + 1 >= FIELD_BYTES[4*f +: 4]) begin
        step_words.push_back(make_word(KIND_FIXED, 4'(f), field_acc, ST_OK, '0));
        field_acc  = '0;
        field_byte = '0;
        phase      = phase + 5'd1;
      end else begin
        field_byte = field_byte + 4'd1;
      end
    end else if (phase < PH_DONE) begin
      // length prefix low, length prefix high, then the string bytes
      rel = int'(phase) - int'(PH_STR0);
      k   = rel / 3;
      case (rel % 3)
        0: begin
          str_left = {8'h00, b};
          phase    = phase + 5'd1;
        end
        1: begin
          str_left[15:8] = b;
          if (str_left == 16'd0) begin
            if (copy_mode)
              step_words.push_back(make_word(KIND_SEND, 4'(FIRST_STRING_IDX + k), '0,
                                             ST_OK, '0));
            advance_string(k);
          end else begin
            phase = phase + 5'd1;
          end
        end
        default: begin
          if (copy_mode)
            step_words.push_back(make_word(KIND_SBYTE, 4'(FIRST_STRING_IDX + k),
                                           {56'd0, b}, ST_OK, '0));
          str_left = str_left - 16'd1;
          if (str_left == 16'd0) begin
            if (copy_mode)
              step_words.push_back(make_word(KIND_SEND, 4'(FIRST_STRING_IDX + k), '0,
                                             ST_OK, '0));
            advance_string(k);
          end
        end
      endcase
    end else begin
      // trailing bytes after the record are ignored
      phase = PH_DONE;
    end

    // position saturates instead of wrapping
    if (pos < POS_MAX) byte_pos = pos + 1'b1;
    if (rec_done && !was_done) end_pos = byte_pos;

    if (eob) begin
      if (!strict_mode)
        st = rec_done ? ST_OK : ST_TRUNC;
      else if (byte_pos < FIX_LEN)
        st = ST_TRUNC;
      else if (byte_pos != {1'b0, declared_size} + 17'd2)
        st = ST_SIZE_ERR;
      else if (!rec_done)
        st = ST_TRUNC;
      else if (end_pos != byte_pos)
        st = ST_TRAILING;
      else
        st = ST_OK;
      step_words.push_back(make_word(KIND_STATUS, '0, '0, st,
                                     (st == ST_OK) ? end_pos : '0));
      clear_parse();
    end

    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endfunction

  // compare before predicting: a byte's words never leave in its own cycle
  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (!rst_n) begin
      strict_mode = 1'b0;
      copy_mode   = 1'b1;
      clear_parse();
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_STRICT)
          strict_mode = cfg_wdata;
        else if (cfg_index == CFG_COPY)
          copy_mode = cfg_wdata;
      end

      if (out_tvalid && out_tready) begin
        got.kind     = kind_t'(out_tuser);
        got.idx      = out_tdata[3:0];
        got.val      = out_tdata[67:4];
        got.status   = status_t'(out_tdata[69:68]);
        got.consumed = out_tdata[86:70];
        got.last     = out_tlast;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word with none expected: kind %0d idx %0d val %h",
                                    got.kind, got.idx, got.val));
        end else begin
          want = expected_words.pop_front();
          if (got.kind !== want.kind || got.idx !== want.idx || got.val !== want.val ||
              got.status !== want.status || got.consumed !== want.consumed ||
              got.last !== want.last)
            report_mismatch($sformatf(
              "got kind %0d idx %0d val %h st %0d len %0d last %b / want %0d %0d %h %0d %0d %b",
              got.kind, got.idx, got.val, got.status, got.consumed, got.last,
              want.kind, want.idx, want.val, want.status, want.consumed, want.last));
        end
      end

      if (in_tvalid && in_tready) parse_stat_byte(in_tdata, in_tlast);
    end
    pending_words = expected_words.size();
  end

endmodule

>>> test/tb_stat_record_parser_core.sv
// Testbench top for stat_record_parser_core: clock, reset, byte stimulus, result
// back-pressure, config writes, watchdog and verdict. Checking is in stat_record_checker.
// Depends on srp_pkg, stat_record_parser_core and stat_record_checker.
module tb_stat_record_parser_core;
  import srp_pkg::*;

  localparam int IDLE_PCT       = 27;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_BYTES    = 60;

  // shapes of generated buffers
  typedef enum int {
    REC_EXACT,
    REC_MIN,
    REC_TRAILING,
    REC_SIZE_BAD,
    REC_CUT,
    REC_NOISE
  } rec_shape_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;   // end_of_buffer
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;  // [3:0] field_index, [67:4] field_value,
                           // [69:68] status_code, [86:70] consumed_length
  logic [1:0]  out_tuser;  // [1:0] result_kind
  logic        out_tlast;  // last_of_item
  logic        cfg_we;
  logic        cfg_index;
  logic        cfg_wdata;

  logic       quiet_mode    = 1'b0;
  int         hold_requests = 0;
  int         hold_seen     = 0;
  int         hold_left     = 0;
  int         stall_count   = 0;
  int         fail_count;
  int         pending_words;
  logic [7:0] rec_bytes[$];

  stat_record_parser_core DUT (.*);

  stat_record_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random back-pressure, long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog: too long without any word moving
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_count <= 0;
    end else if (stall_count >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // all expected words out, then let any word-less byte settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input logic strict, input logic copy);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STRICT;
    cfg_wdata <= strict;
    @(negedge clk);
    cfg_index <= CFG_COPY;
    cfg_wdata <= copy;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pattern_byte(input int mode);
    return (mode == 0) ? 8'h00 : (mode == 1) ? 8'hFF : 8'($urandom);
  endfunction

  // fill rec_bytes with one stat buffer of the given shape
  function automatic void build_record(input rec_shape_t shape);
    logic [15:0] slen;
    logic [15:0] size_word;
    int          fill_mode;
    int          keep;
    rec_bytes.delete();
    fill_mode = $urandom_range(9);
    if (shape == REC_NOISE) begin
      repeat ($urandom_range(1, 60)) rec_bytes.push_back(8'($urandom));
      return;
    end
    // size word slot, then 39 bytes of fixed fields
    rec_bytes.push_back(8'h00);
    rec_bytes.push_back(8'h00);
    repeat (39) rec_bytes.push_back(pattern_byte(fill_mode));
    // name, uid, gid, muid
    for (int k = 0; k < 4; k++) begin
      if (shape == REC_MIN)
        slen = 16'd0;
      else if (shape == REC_CUT && k == 3 && $urandom_range(1) == 1)
        slen = 16'($urandom_range(256, 280));
      else
        slen = ($urandom_range(99) < 30) ? 16'd0 : 16'($urandom_range(1, 6));
      rec_bytes.push_back(slen[7:0]);
      rec_bytes.push_back(slen[15:8]);
      repeat (slen) rec_bytes.push_back(pattern_byte(fill_mode));
    end
    if (shape == REC_TRAILING)
      repeat ($urandom_range(1, 4)) rec_bytes.push_back(8'($urandom));
    if (shape == REC_CUT) begin
      keep = $urandom_range(1, (rec_bytes.size() - 1 < 90) ? rec_bytes.size() - 1 : 90);
      while (rec_bytes.size() > keep) void'(rec_bytes.pop_back());
    end
    size_word = 16'(rec_bytes.size() - 2);
    if (shape == REC_SIZE_BAD)
      size_word = size_word ^ 16'($urandom_range(1, 65535));
    else if (shape == REC_CUT && $urandom_range(1) == 1)
      size_word = 16'($urandom);
    rec_bytes[0] = size_word[7:0];
    if (rec_bytes.size() > 1) rec_bytes[1] = size_word[15:8];
  endfunction

  initial begin : stimulus
    int         sent;
    int         r;
    rec_shape_t shape;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_STRICT;
    cfg_wdata = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // short buffers at reset mode: one byte, two bytes, cut inside the fixed fields
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    for (int i = 0; i < 20; i++) send_byte(i[0] ? 8'h00 : 8'hFF, i == 19);

    // random buffers under each mode pair
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      set_mode(p < 2, p == 0 || p == 3);
      quiet_mode = (p == 2);
      // result side holds off while bytes keep coming
      if (p == 0) hold_requests = hold_requests + 1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        r = $urandom_range(99);
        shape = (r < 35) ? REC_EXACT : (r < 45) ? REC_MIN : (r < 60) ? REC_TRAILING :
                (r < 72) ? REC_SIZE_BAD : (r < 88) ? REC_CUT : REC_NOISE;
        build_record(shape);
        foreach (rec_bytes[i]) send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
        sent += rec_bytes.size();
      end
    end
    quiet_mode = 1'b0;

    wait_idle();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
